[hdl/pfla_pkg.sv]
// Shared types, codes and defaults for the page free-list allocator.
// Used by pfla_cfg_regs and page_free_list_allocator; depends on nothing.
package pfla_pkg;

  localparam int AddrW = 40;
  localparam int PaddrW = 4;
  localparam int PdataW = 64;

  localparam int PageShiftDefault = 12;
  localparam int PageCountDefault = 4096;

  localparam logic [AddrW-1:0] RegionStartReset = 40'h00_4000_0000;
  localparam logic [AddrW-1:0] RegionEndReset = 40'h00_4100_0000;

  // Register index, taken from paddr[3] (registers are 8 bytes apart).
  localparam logic RegRegionStart = 1'b0;
  localparam logic RegRegionEnd = 1'b1;

  localparam logic [1:0] KindFreeRange = 2'd0;
  localparam logic [1:0] KindFreePage = 2'd1;
  localparam logic [1:0] KindAlloc = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusMisaligned = 2'd1;
  localparam logic [1:0] StatusOutside = 2'd2;
  localparam logic [1:0] StatusEmpty = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] end_address;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] page_address;
    logic             granted;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] region_start;
    logic [AddrW-1:0] region_end;
  } cfg_t;

endpackage

[hdl/pfla_cfg_regs.sv]
// APB-style register file holding the managed region bounds.
// Depends on pfla_pkg for the register codes, reset values and cfg_t.
module pfla_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [pfla_pkg::PaddrW-1:0] paddr_i,
  input  logic [pfla_pkg::PdataW-1:0] pwdata_i,
  output logic [pfla_pkg::PdataW-1:0] prdata_o,
  output logic                       pready_o,
  output pfla_pkg::cfg_t             cfg_o
);

  logic [pfla_pkg::AddrW-1:0] start_q, start_d;
  logic [pfla_pkg::AddrW-1:0] end_q, end_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign wr_en = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_sel = paddr_i[3];
  assign pready_o = 1'b1;

  always_comb begin
    start_d = start_q;
    end_d = end_q;
    if (wr_en) begin
      case (reg_sel)
        pfla_pkg::RegRegionStart: start_d = pwdata_i[pfla_pkg::AddrW-1:0];
        pfla_pkg::RegRegionEnd:   end_d = pwdata_i[pfla_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= pfla_pkg::RegionStartReset;
      end_q <= pfla_pkg::RegionEndReset;
    end else begin
      start_q <= start_d;
      end_q <= end_d;
    end
  end

  always_comb begin
    case (reg_sel)
      pfla_pkg::RegRegionStart: prdata_o = pfla_pkg::PdataW'(start_q);
      pfla_pkg::RegRegionEnd:   prdata_o = pfla_pkg::PdataW'(end_q);
      default:                  prdata_o = '0;
    endcase
  end

  assign cfg_o.region_start = start_q;
  assign cfg_o.region_end = end_q;

endmodule

[hdl/page_free_list_allocator.sv]
// Top level of the page free-list allocator: sequencer, head register and link memory.
// Depends on pfla_pkg and instantiates pfla_cfg_regs.
//
//   Channel   Direction  Handshake              Payload
//   --------  ---------  ---------------------  ---------------------------------
//   in        sink       in_valid_i/in_ready_o  in_data_i  (kind, address, end)
//   out       source     out_valid_o/out_ready_i out_data_o (page, granted, status)
//   cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata (64 bits)
//
// One item is processed at a time. A page free or a rejected item passes through the
// prep, eval, decide and emit states; an allocation adds a pop state for the link
// memory read; a range free stays in the push state until every page is pushed, since
// every push is a write into the single-port link memory. The prep, eval and decide
// states evaluate the region arithmetic in stages of one wide add or compare each.
// Reset clears the sequencer, the head register and the empty flag at once; the link
// memory is not cleared, as an entry is only read after it was pushed. A result waits
// in the output register while the next transfer in is accepted; the sequencer only
// stalls in its final cycle if the previous result has not been taken yet.
module page_free_list_allocator #(
  parameter int PAGE_SHIFT = pfla_pkg::PageShiftDefault,
  parameter int PAGE_COUNT = pfla_pkg::PageCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfla_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfla_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfla_pkg::PaddrW-1:0] paddr,
  input  logic [pfla_pkg::PdataW-1:0] pwdata,
  output logic [pfla_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  localparam int AW = pfla_pkg::AddrW;
  // Page number width, and one more bit for rounded-up or capped page numbers.
  localparam int PnW = AW - PAGE_SHIFT;
  localparam int PnxW = PnW + 1;
  localparam int IdxW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  // A link entry is a valid bit above the index of the next page.
  localparam int LinkW = IdxW + 1;
  localparam logic [AW:0] PageMask = {{(AW + 1 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StEval = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StPush = 3'd4;
  localparam logic [2:0] StPop = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  pfla_pkg::cfg_t cfg;

  pfla_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Control state.
  logic [2:0]      state_q;
  logic            nonempty_q;
  logic [IdxW-1:0] head_q;
  logic            out_valid_q;

  // The captured item and the staged region arithmetic.
  pfla_pkg::in_item_t  item_q;
  pfla_pkg::out_item_t res_q;
  pfla_pkg::out_item_t out_q;
  logic [PnW-1:0]      base_q;
  logic [PnxW-1:0]     vlo_q, vhi_raw_q, cap_q, vhi_q;
  logic [PnxW-1:0]     lo_q, clo_q, chi_q, cur_pn_q;
  logic [PnW-1:0]      hi_q;
  logic                misaligned_q, outside_q, range_q;
  logic [IdxW-1:0]     cur_idx_q;

  // Link memory: next page index of every listed page.
  logic [LinkW-1:0] link_mem [PAGE_COUNT];
  logic [LinkW-1:0] link_rd_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr;
  logic [LinkW-1:0] mem_wdata;

  // Combinational helpers for the staged arithmetic.
  logic [AW:0]        vlo_sum, vhi_sum, lo_sum;
  logic [PnW-1:0]     addr_pn;
  logic [PnxW-1:0]    chi;
  logic               range_bad;
  logic [PnxW-1:0]    pop_pn;
  logic [PnxW+PAGE_SHIFT-1:0] pop_addr;

  assign vlo_sum = {1'b0, cfg.region_start} + PageMask;
  assign vhi_sum = {1'b0, cfg.region_end} + PageMask;
  assign lo_sum = {1'b0, item_q.address} + PageMask;
  assign addr_pn = item_q.address[AW-1:PAGE_SHIFT];

  // Upper bound of the pushed pages, and whether any whole page got clipped.
  assign chi = (PnxW'(hi_q) < vhi_q) ? PnxW'(hi_q) : vhi_q;
  assign range_bad = (clo_q >= chi) || (clo_q > lo_q) || (chi < PnxW'(hi_q));

  // Allocated address is rebuilt from the current region base.
  assign pop_pn = PnxW'(base_q) + PnxW'(head_q);
  assign pop_addr = {pop_pn, {PAGE_SHIFT{1'b0}}};

  // A push writes the old head behind the new page; a pop reads the head's link.
  assign mem_we = ((state_q == StDecide) && (item_q.kind == pfla_pkg::KindFreePage)
                   && !misaligned_q && !outside_q) || (state_q == StPush);
  assign mem_waddr = cur_idx_q;
  assign mem_wdata = nonempty_q ? {1'b1, head_q} : '0;
  assign mem_re = (state_q == StDecide) && (item_q.kind == pfla_pkg::KindAlloc) && nonempty_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_q <= link_mem[head_q];
    end
  end

  // Sequencer and list head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nonempty_q <= 1'b0;
      head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the emit state the output flag is handled below, where a new result may
      // replace the one that leaves in the same cycle.
      if (out_valid_q && out_ready_i && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          state_q <= StEval;
        end
        StEval: begin
          state_q <= StDecide;
        end
        StDecide: begin
          if (mem_we) begin
            head_q <= mem_waddr;
            nonempty_q <= 1'b1;
          end
          if (mem_re) begin
            state_q <= StPop;
          end else if ((item_q.kind == pfla_pkg::KindFreeRange) && range_q && (clo_q < chi)) begin
            state_q <= StPush;
          end else begin
            state_q <= StEmit;
          end
        end
        StPush: begin
          head_q <= mem_waddr;
          nonempty_q <= 1'b1;
          if ((cur_pn_q + PnxW'(1)) == chi_q) begin
            state_q <= StEmit;
          end
        end
        StPop: begin
          nonempty_q <= link_rd_q[IdxW];
          head_q <= link_rd_q[IdxW] ? link_rd_q[IdxW-1:0] : '0;
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload and arithmetic stages; no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        item_q <= in_data_i;
      end
      StPrep: begin
        base_q <= cfg.region_start[AW-1:PAGE_SHIFT];
        vlo_q <= vlo_sum[AW:PAGE_SHIFT];
        vhi_raw_q <= vhi_sum[AW:PAGE_SHIFT];
        cap_q <= PnxW'(cfg.region_start[AW-1:PAGE_SHIFT]) + PnxW'(PAGE_COUNT);
        lo_q <= lo_sum[AW:PAGE_SHIFT];
        hi_q <= item_q.end_address[AW-1:PAGE_SHIFT];
        misaligned_q <= |item_q.address[PAGE_SHIFT-1:0];
        outside_q <= (item_q.address < cfg.region_start)
                     || (item_q.address >= cfg.region_end);
      end
      StEval: begin
        vhi_q <= (vhi_raw_q > cap_q) ? cap_q : vhi_raw_q;
        clo_q <= (lo_q > vlo_q) ? lo_q : vlo_q;
        range_q <= lo_q < PnxW'(hi_q);
        outside_q <= outside_q || (PnxW'(addr_pn) >= cap_q);
        cur_idx_q <= IdxW'(addr_pn - base_q);
      end
      StDecide: begin
        res_q.page_address <= '0;
        res_q.granted <= 1'b0;
        cur_pn_q <= clo_q;
        chi_q <= chi;
        cur_idx_q <= IdxW'(clo_q - PnxW'(base_q));
        case (item_q.kind)
          pfla_pkg::KindFreeRange: begin
            res_q.status <= (range_q && range_bad) ? pfla_pkg::StatusOutside
                                                   : pfla_pkg::StatusOk;
          end
          pfla_pkg::KindFreePage: begin
            if (misaligned_q) begin
              res_q.status <= pfla_pkg::StatusMisaligned;
            end else if (outside_q) begin
              res_q.status <= pfla_pkg::StatusOutside;
            end else begin
              res_q.status <= pfla_pkg::StatusOk;
            end
          end
          pfla_pkg::KindAlloc: begin
            res_q.status <= nonempty_q ? pfla_pkg::StatusOk : pfla_pkg::StatusEmpty;
          end
          default: res_q.status <= pfla_pkg::StatusOk;
        endcase
      end
      StPush: begin
        cur_pn_q <= cur_pn_q + PnxW'(1);
        cur_idx_q <= cur_idx_q + IdxW'(1);
      end
      StPop: begin
        res_q.page_address <= pop_addr[AW-1:0];
        res_q.granted <= 1'b1;
        res_q.status <= pfla_pkg::StatusOk;
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // The link memory port never reads and writes in the same cycle.
  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("link memory read and write collide");

  // A pop is only issued on a list that holds a page.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> nonempty_q)
    else $error("pop issued on an empty list");

  // After any push the list is not empty.
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> nonempty_q)
    else $error("list empty after a push");

  // A granted page always carries an ok status.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.granted) |-> (out_data_o.status == pfla_pkg::StatusOk))
    else $error("granted result with a failure status");

  // A new result appears only out of the final sequencer state.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StEmit))
    else $error("result raised outside the emit state");

endmodule
